// File: hw/rtl/bsr_pkg.sv
package bsr_pkg;

  // field widths
  localparam int unsigned OpW     = 3;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned AdcW    = 10;
  localparam int unsigned PtrW    = 4;
  localparam int unsigned MvW     = 16;

  // divider sizing: dividend is 1024 * reference
  localparam int unsigned DivShift = 10;
  localparam int unsigned DvdW     = MvW + DivShift;
  localparam int unsigned CntW     = $clog2(DvdW);
  localparam int unsigned VoltW    = 13;

  localparam int unsigned NumRegsDef = 12;

  // operations
  typedef enum logic [OpW-1:0] {
    OP_PTR   = 3'd0,
    OP_WRITE = 3'd1,
    OP_READ  = 3'd2,
    OP_ADC   = 3'd3,
    OP_TICK  = 3'd4
  } op_e;

  // register map
  localparam logic [PtrW-1:0] REG_STATUS  = 4'd0;
  localparam logic [PtrW-1:0] REG_SLEEP   = 4'd1;
  localparam logic [PtrW-1:0] REG_SHOWN_L = 4'd2;
  localparam logic [PtrW-1:0] REG_SHOWN_H = 4'd3;
  localparam logic [PtrW-1:0] REG_REF_L   = 4'd4;
  localparam logic [PtrW-1:0] REG_REF_H   = 4'd5;
  localparam logic [PtrW-1:0] REG_MIN_L   = 4'd6;
  localparam logic [PtrW-1:0] REG_MIN_H   = 4'd7;
  localparam logic [PtrW-1:0] REG_MAX_L   = 4'd8;
  localparam logic [PtrW-1:0] REG_MAX_H   = 4'd9;
  localparam logic [PtrW-1:0] REG_HYS_L   = 4'd10;
  localparam logic [PtrW-1:0] REG_HYS_H   = 4'd11;

  // reset values and plausibility limits in mV
  localparam logic [MvW-1:0] REF_RST   = 16'd1100;
  localparam logic [MvW-1:0] MIN_RST   = 16'd3700;
  localparam logic [MvW-1:0] MAX_RST   = 16'd4200;
  localparam logic [MvW-1:0] HYS_RST   = 16'd4000;
  localparam logic [VoltW-1:0] V_LOW   = 13'd1800;
  localparam logic [VoltW-1:0] V_HIGH  = 13'd5500;

  // divider handshake
  typedef struct packed {
    logic              start;
    logic [DvdW-1:0]   dividend;
    logic [AdcW-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DvdW-1:0]   quotient;
  } div_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_COMMIT
  } state_e;

endpackage

// File: hw/rtl/bsr_intf.sv
interface bsr_in_if;
  import bsr_pkg::*;
  logic               valid;
  logic               ready;
  logic [OpW-1:0]     operation;
  logic [ByteW-1:0]   data_byte;
  logic [AdcW-1:0]    adc_value;

  modport source (output valid, output operation, output data_byte, output adc_value,
                  input ready);
  modport sink   (input valid, input operation, input data_byte, input adc_value,
                  output ready);
endinterface

interface bsr_out_if;
  import bsr_pkg::*;
  logic               valid;
  logic               ready;
  logic [ByteW-1:0]   read_data;
  logic               charge_enable;
  logic               rail_enable;
  logic               measurement_valid;
  logic               reconvert_request;
  logic               settings_dirty;
  logic               sleep_active;

  modport source (output valid, output read_data, output charge_enable,
                  output rail_enable, output measurement_valid,
                  output reconvert_request, output settings_dirty,
                  output sleep_active, input ready);
  modport sink   (input valid, input read_data, input charge_enable,
                  input rail_enable, input measurement_valid,
                  input reconvert_request, input settings_dirty,
                  input sleep_active, output ready);
endinterface

// File: hw/rtl/bsr_div.sv
module bsr_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bsr_pkg::div_req_t  req_i,
  output bsr_pkg::div_rsp_t  rsp_o
);
  import bsr_pkg::*;

  logic              busy_q, busy_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [AdcW-1:0]   rem_q, rem_d;
  logic [DvdW-1:0]   quo_q, quo_d;
  logic [AdcW-1:0]   dvs_q, dvs_d;
  logic              done_q, done_d;
  logic [AdcW:0]     trial;
  logic [AdcW:0]     diff;
  logic              fits;

  // one restoring step: bring down one dividend bit, try the subtract
  always_comb begin
    trial = {rem_q, quo_q[DvdW-1]};
    diff  = trial - {1'b0, dvs_q};
    fits  = (trial >= {1'b0, dvs_q});
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DvdW - 1);
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? diff[AdcW-1:0] : trial[AdcW-1:0];
      quo_d = {quo_q[DvdW-2:0], fits};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath shift registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// File: hw/rtl/battery_supervisor_regs.sv
// battery supervisor behind a byte-wide register file
// in_i carries one command per transfer: set pointer, write byte, read byte,
// adc sample or watchdog tick. out_o returns exactly one result per command:
// the read byte (zero unless a read) and the status flags after the update.
// both channels use valid/ready; a command is taken on valid & ready.
// bus and tick commands pass through the commit step to the output register;
// an awake adc sample with nonzero raw runs a bit-serial divider,
// one quotient bit per cycle over 26 bits, before its commit step.
// a new command is taken only once the previous one has committed;
// for adc samples the 26-step divider sets the sample rate.
// the input is accepted again as soon as a command commits, even while its
// result still sits in the output register. a stalled output holds its
// result and the next command waits in its commit step until it is taken.
// reset: pointer 0, sleep count 0, thresholds 1100/3700/4200/4000 mV,
// charging on, rail off, no valid reading, settings clean.
module battery_supervisor_regs #(
  parameter int unsigned NUM_REGS = bsr_pkg::NumRegsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bsr_in_if.sink      in_i,
  bsr_out_if.source   out_o
);
  import bsr_pkg::*;

  state_e            state_q, state_d;
  logic [OpW-1:0]    op_q;
  logic [ByteW-1:0]  data_q;
  logic              raw_zero_q;

  logic [PtrW-1:0]   ptr_q, ptr_d;
  logic [ByteW-1:0]  sleep_q, sleep_d;
  logic [MvW-1:0]    ref_q, ref_d;
  logic [MvW-1:0]    min_q, min_d;
  logic [MvW-1:0]    max_q, max_d;
  logic [MvW-1:0]    hys_q, hys_d;
  logic [MvW-1:0]    supply_q, supply_d;
  logic [MvW-1:0]    shown_q, shown_d;
  logic              valid_q, valid_d;
  logic              charge_q, charge_d;
  logic              rail_q, rail_d;
  logic              dirty_q, dirty_d;

  logic              ovalid_q, ovalid_d;
  logic [ByteW-1:0]  rdata_q, rdata_d;
  logic              recon_q, recon_d;

  logic              in_fire;
  logic              out_free;
  logic              commit;
  logic              div_go;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic [PtrW:0]     ptr_inc;
  logic [PtrW-1:0]   ptr_next;
  logic              in_range;
  logic [ByteW-1:0]  rd_byte;
  logic [VoltW-1:0]  volt;
  logic [MvW-1:0]    volt_w;
  logic              plausible;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid & in_i.ready;
  assign out_free   = !ovalid_q || out_o.ready;
  assign commit     = (state_q == ST_COMMIT) && out_free;

  // start the divider right at the transfer for an awake nonzero sample
  assign div_go = in_fire && (in_i.operation == OP_ADC) && (sleep_q == '0)
                  && (in_i.adc_value != '0);
  assign div_req.start    = div_go;
  assign div_req.dividend = {ref_q, {DivShift{1'b0}}};
  assign div_req.divisor  = in_i.adc_value;

  bsr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = div_go ? ST_DIV : ST_COMMIT;
      end
      ST_DIV: begin
        if (div_rsp.done) state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // pointer increment with wrap
  always_comb begin
    ptr_inc  = {1'b0, ptr_q} + 1'b1;
    ptr_next = (ptr_inc >= (PtrW+1)'(NUM_REGS)) ? '0 : ptr_inc[PtrW-1:0];
    in_range = ({1'b0, ptr_q} < (PtrW+1)'(NUM_REGS));
  end

  // register read mux
  always_comb begin
    rd_byte = '0;
    if (in_range) begin
      unique case (ptr_q)
        REG_STATUS:  rd_byte = {{(ByteW-1){1'b0}}, valid_q};
        REG_SLEEP:   rd_byte = sleep_q;
        REG_SHOWN_L: rd_byte = shown_q[7:0];
        REG_SHOWN_H: rd_byte = shown_q[15:8];
        REG_REF_L:   rd_byte = ref_q[7:0];
        REG_REF_H:   rd_byte = ref_q[15:8];
        REG_MIN_L:   rd_byte = min_q[7:0];
        REG_MIN_H:   rd_byte = min_q[15:8];
        REG_MAX_L:   rd_byte = max_q[7:0];
        REG_MAX_H:   rd_byte = max_q[15:8];
        REG_HYS_L:   rd_byte = hys_q[7:0];
        REG_HYS_H:   rd_byte = hys_q[15:8];
        default:     rd_byte = '0;
      endcase
    end
  end

  // quotient check: fits in 13 bits and lies strictly inside the limits
  always_comb begin
    volt      = div_rsp.quotient[VoltW-1:0];
    volt_w    = {{(MvW-VoltW){1'b0}}, volt};
    plausible = (div_rsp.quotient[DvdW-1:VoltW] == '0) && (volt > V_LOW)
                && (volt < V_HIGH);
  end

  // state update at commit
  always_comb begin
    ptr_d    = ptr_q;
    sleep_d  = sleep_q;
    ref_d    = ref_q;
    min_d    = min_q;
    max_d    = max_q;
    hys_d    = hys_q;
    supply_d = supply_q;
    shown_d  = shown_q;
    valid_d  = valid_q;
    charge_d = charge_q;
    rail_d   = rail_q;
    dirty_d  = dirty_q;
    rdata_d  = '0;
    recon_d  = 1'b0;
    if (commit) begin
      case (op_q)
        OP_PTR: ptr_d = data_q[PtrW-1:0];
        OP_WRITE: begin
          ptr_d = ptr_next;
          if (in_range) begin
            case (ptr_q)
              REG_SLEEP: begin
                sleep_d = data_q;
                if (data_q != '0) begin
                  rail_d = 1'b0;
                  if (supply_q <= max_q) begin
                    shown_d = '0;
                    valid_d = 1'b0;
                  end
                end
              end
              REG_REF_L: begin ref_d[7:0]  = data_q; dirty_d = 1'b1; end
              REG_REF_H: begin ref_d[15:8] = data_q; dirty_d = 1'b1; end
              REG_MIN_L: begin min_d[7:0]  = data_q; dirty_d = 1'b1; end
              REG_MIN_H: begin min_d[15:8] = data_q; dirty_d = 1'b1; end
              REG_MAX_L: begin max_d[7:0]  = data_q; dirty_d = 1'b1; end
              REG_MAX_H: begin max_d[15:8] = data_q; dirty_d = 1'b1; end
              REG_HYS_L: begin hys_d[7:0]  = data_q; dirty_d = 1'b1; end
              REG_HYS_H: begin hys_d[15:8] = data_q; dirty_d = 1'b1; end
              default: ;
            endcase
          end
        end
        OP_READ: begin
          rdata_d = rd_byte;
          ptr_d   = ptr_next;
        end
        OP_ADC: begin
          if (sleep_q == '0) begin
            if (raw_zero_q || !plausible) begin
              recon_d = 1'b1;
            end else begin
              supply_d = volt_w;
              if (volt_w <= hys_q) charge_d = 1'b1;
              else if (volt_w >= max_q) charge_d = 1'b0;
              if (volt_w < min_q) begin
                rail_d  = 1'b0;
                shown_d = '0;
                valid_d = 1'b0;
              end else begin
                rail_d  = 1'b1;
                shown_d = volt_w;
                valid_d = 1'b1;
              end
            end
          end
        end
        OP_TICK: begin
          if (sleep_q != '0) sleep_d = sleep_q - 1'b1;
        end
        default: ;
      endcase
    end
  end

  // output register
  always_comb begin
    ovalid_d = ovalid_q;
    if (commit) ovalid_d = 1'b1;
    else if (out_o.ready) ovalid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ptr_q    <= '0;
      sleep_q  <= '0;
      ref_q    <= REF_RST;
      min_q    <= MIN_RST;
      max_q    <= MAX_RST;
      hys_q    <= HYS_RST;
      supply_q <= '0;
      shown_q  <= '0;
      valid_q  <= 1'b0;
      charge_q <= 1'b1;
      rail_q   <= 1'b0;
      dirty_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ptr_q    <= ptr_d;
      sleep_q  <= sleep_d;
      ref_q    <= ref_d;
      min_q    <= min_d;
      max_q    <= max_d;
      hys_q    <= hys_d;
      supply_q <= supply_d;
      shown_q  <= shown_d;
      valid_q  <= valid_d;
      charge_q <= charge_d;
      rail_q   <= rail_d;
      dirty_q  <= dirty_d;
      ovalid_q <= ovalid_d;
    end
  end

  // command capture and result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q       <= in_i.operation;
      data_q     <= in_i.data_byte;
      raw_zero_q <= (in_i.adc_value == '0);
    end
    if (commit) begin
      rdata_q <= rdata_d;
      recon_q <= recon_d;
    end
  end

  assign out_o.valid             = ovalid_q;
  assign out_o.read_data         = rdata_q;
  assign out_o.charge_enable     = charge_q;
  assign out_o.rail_enable       = rail_q;
  assign out_o.measurement_valid = valid_q;
  assign out_o.reconvert_request = recon_q;
  assign out_o.settings_dirty    = dirty_q;
  assign out_o.sleep_active      = (sleep_q != '0);

endmodule
